>>> sv/ts_packet_sync_search_assert.svh
// ---------------------------------------------------------------------------
// ts_packet_sync_search assertion macros
// Shared concurrent assertion forms for the sync search RTL.
// ---------------------------------------------------------------------------
`ifndef TS_PACKET_SYNC_SEARCH_ASSERT_SVH
`define TS_PACKET_SYNC_SEARCH_ASSERT_SVH

// Assertion checked on every clock edge outside reset.
`define TPSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion checked on every clock edge, reset included.
`define TPSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ts_pss_pkg.sv
// ---------------------------------------------------------------------------
// ts_pss_pkg
// Types and constants shared by the transport stream sync search modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ts_pss_pkg;

   localparam int unsigned BITS_PER_BYTE = 8;
   localparam int unsigned SKIP_W        = 11;
   localparam int unsigned CONF_W        = 4;
   localparam logic [3:0]  CONF_MAX      = 4'd15;

   // Register reset values
   localparam logic [7:0] SYNC_PATTERN_RST     = 8'd71;
   localparam logic [7:0] INV_SYNC_PATTERN_RST = 8'd184;
   localparam logic [7:0] PACKET_BYTES_RST     = 8'd204;
   localparam logic [3:0] CONF_LIMIT_RST       = 4'd3;

   // Register indexes on the configuration port
   typedef enum logic [1:0] {
      CSR_SYNC_PATTERN     = 2'd0,
      CSR_INV_SYNC_PATTERN = 2'd1,
      CSR_PACKET_BYTES     = 2'd2,
      CSR_CONF_LIMIT       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_UNLOCKED = 2'd0,
      MODE_SEEKING  = 2'd1,
      MODE_SYNCED   = 2'd2
   } lock_mode_type;

   typedef struct packed {
      logic [7:0] sync_pattern;
      logic [7:0] inv_sync_pattern;
      logic [7:0] packet_bytes;
      logic [3:0] conf_limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] byte_position;
   } result_type;

endpackage

`default_nettype wire

>>> sv/ts_pss_csr.sv
// ---------------------------------------------------------------------------
// ts_pss_csr
// Configuration register file, written over the csr valid/ready channel.
// ---------------------------------------------------------------------------
`default_nettype none

module ts_pss_csr (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire ts_pss_pkg::csr_index_type csr_index,
   input  wire logic [7:0]             csr_data,
   output ts_pss_pkg::cfg_type         cfg
);
   import ts_pss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always take a write transfer
   assign csr_ready = 1'b1;

   // Select the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SYNC_PATTERN:     cfg_in.sync_pattern     = csr_data;
            CSR_INV_SYNC_PATTERN: cfg_in.inv_sync_pattern = csr_data;
            CSR_PACKET_BYTES:     cfg_in.packet_bytes     = csr_data;
            CSR_CONF_LIMIT:       cfg_in.conf_limit       = csr_data[3:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_pattern     <= SYNC_PATTERN_RST;
         cfg_ff.inv_sync_pattern <= INV_SYNC_PATTERN_RST;
         cfg_ff.packet_bytes     <= PACKET_BYTES_RST;
         cfg_ff.conf_limit       <= CONF_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> sv/ts_pss_core.sv
// ---------------------------------------------------------------------------
// ts_pss_core
// Per-bit lock state update: window shift, skip counter, mode and confidence.
// ---------------------------------------------------------------------------
`default_nettype none

module ts_pss_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic                rx_bit,
   input  wire ts_pss_pkg::cfg_type cfg,
   output logic                     emit,
   output ts_pss_pkg::result_type   result
);
   import ts_pss_pkg::*;

   lock_mode_type     mode_ff,   mode_in;
   logic [7:0]        window_ff, window_in;
   logic [CONF_W-1:0] conf_ff,   conf_in;
   logic [SKIP_W-1:0] skip_ff,   skip_in;
   logic [7:0]        count_ff,  count_in;

   logic [7:0]        eff_packet;
   logic [CONF_W-1:0] eff_limit;
   logic [SKIP_W-1:0] spacing;
   logic [CONF_W-1:0] conf_inc;
   logic [8:0]        count_inc;
   logic              hit_sync;
   logic              hit_inv;

   // Zero length and zero limit behave as one
   assign eff_packet = (cfg.packet_bytes == 8'd0) ? 8'd1 : cfg.packet_bytes;
   assign eff_limit  = (cfg.conf_limit == 4'd0) ? 4'd1 : cfg.conf_limit;
   assign spacing    = {eff_packet, 3'b000};
   assign window_in  = {window_ff[6:0], rx_bit};
   assign hit_sync   = (window_in == cfg.sync_pattern);
   assign hit_inv    = (window_in == cfg.inv_sync_pattern);
   assign conf_inc   = (conf_ff < CONF_MAX) ? conf_ff + 4'd1 : conf_ff;
   assign count_inc  = {1'b0, count_ff} + 9'd1;

   // Next state for one received bit
   always_comb begin
      mode_in  = mode_ff;
      conf_in  = conf_ff;
      skip_in  = skip_ff;
      count_in = count_ff;
      emit     = 1'b0;
      if (skip_ff > 11'd1) begin
         skip_in = skip_ff - 11'd1;
      end else begin
         unique case (mode_ff)
            MODE_SEEKING: begin
               if (hit_sync) begin
                  conf_in = eff_limit;
                  skip_in = spacing;
               end else if (hit_inv) begin
                  conf_in = eff_limit;
                  mode_in = MODE_SYNCED;
                  emit    = 1'b1;
                  skip_in = SKIP_W'(BITS_PER_BYTE);
               end else if (conf_ff <= 4'd1) begin
                  conf_in = '0;
                  mode_in = MODE_UNLOCKED;
                  skip_in = 11'd1;
               end else begin
                  conf_in = conf_ff - 4'd1;
                  skip_in = spacing;
               end
            end
            MODE_SYNCED: begin
               emit    = 1'b1;
               skip_in = SKIP_W'(BITS_PER_BYTE);
               // Packet boundary: check the sync byte
               if (count_inc >= {1'b0, eff_packet}) begin
                  count_in = '0;
                  if (hit_sync || hit_inv) begin
                     conf_in = eff_limit;
                  end else if (conf_ff <= 4'd1) begin
                     conf_in = '0;
                     emit    = 1'b0;
                     mode_in = MODE_UNLOCKED;
                     skip_in = 11'd1;
                  end else begin
                     conf_in = conf_ff - 4'd1;
                  end
               end else begin
                  count_in = count_inc[7:0];
               end
            end
            // Unlocked, and the unused code that behaves as unlocked
            default: begin
               mode_in = MODE_UNLOCKED;
               if (hit_sync) begin
                  conf_in = conf_inc;
                  if (conf_inc >= eff_limit) begin
                     mode_in = MODE_SEEKING;
                  end
                  skip_in = spacing;
               end else if (conf_ff != 4'd0) begin
                  conf_in = conf_ff - 4'd1;
                  skip_in = spacing;
               end else begin
                  skip_in = 11'd1;
               end
            end
         endcase
      end
   end

   // Advance state on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_UNLOCKED;
         window_ff <= '0;
         conf_ff   <= '0;
         skip_ff   <= 11'd1;
         count_ff  <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         window_ff <= window_in;
         conf_ff   <= conf_in;
         skip_ff   <= skip_in;
         count_ff  <= count_in;
      end
   end

   assign result.data_byte     = window_in;
   assign result.byte_position = count_in;

`include "ts_packet_sync_search_assert.svh"

   `TPSS_ASSERT(a_skip_nonzero, clock, reset, skip_ff != 11'd0, "skip count reached zero")
   `TPSS_ASSERT(a_locked_conf, clock, reset, (mode_ff != MODE_UNLOCKED) |-> (conf_ff != 4'd0), "locked with zero confidence")
   `TPSS_ASSERT(a_emit_synced, clock, reset, (accept && emit) |=> (mode_ff == MODE_SYNCED), "byte emitted outside synced mode")

endmodule

`default_nettype wire

>>> sv/ts_pss_out.sv
// ---------------------------------------------------------------------------
// ts_pss_out
// Result register with a skid stage between the core and the rsp channel.
// ---------------------------------------------------------------------------
`default_nettype none

module ts_pss_out (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire ts_pss_pkg::result_type push_data,
   output logic                        can_push,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output ts_pss_pkg::result_type      rsp_data
);
   import ts_pss_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop = main_valid_ff && rsp_ready;

   // Refill the result register from skid first, then from the core
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign can_push  = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

`include "ts_packet_sync_search_assert.svh"

   `TPSS_ASSERT(a_skid_behind_main, clock, reset, skid_valid_ff |-> main_valid_ff, "skid holds data with empty result register")
   `TPSS_ASSERT(a_skid_on_stall, clock, reset, $rose(skid_valid_ff) |-> $past(main_valid_ff && !rsp_ready), "skid filled without a stall")
   `TPSS_ASSERT(a_skid_drains, clock, reset, (skid_valid_ff && rsp_ready) |=> main_valid_ff, "skid data lost on transfer")

endmodule

`default_nettype wire

>>> sv/ts_packet_sync_search.sv
// ---------------------------------------------------------------------------
// ts_packet_sync_search
// Serial transport stream sync byte search and byte alignment.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one received bit per transfer (req_rx_bit), valid/ready.
//   rsp channel: one aligned data byte and its position in the packet,
//   produced only while synced, at most one per input bit.
//   csr channel: register index and data; always ready, one write a cycle.
// Throughput: one input bit per cycle while req_ready is high. The lock state is
//   updated in the cycle the bit transfers; the result register follows.
// Output: each result reaches rsp from the result register, via the skid on a stall.
// Stall: a two-entry output (result register plus skid) absorbs one extra
//   result while rsp_ready is low; req_ready drops only while the skid
//   stage is full, and rises again once the receiver takes a result.
// Reset: synchronous, active high. Registers return to their defaults,
//   mode to unlocked, confidence and byte count to zero, skip count to one,
//   and both output entries are emptied. No clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module ts_packet_sync_search (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_rx_bit,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [7:0]                     rsp_data_byte,
   output logic [7:0]                     rsp_byte_position,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire ts_pss_pkg::csr_index_type csr_index,
   input  wire logic [7:0]                csr_data
);
   import ts_pss_pkg::*;

   cfg_type    cfg;
   result_type core_result;
   result_type out_result;
   logic       core_emit;
   logic       can_push;
   logic       accept;

   assign req_ready = can_push;
   assign accept    = req_valid && req_ready;

   // Configuration registers
   ts_pss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Lock state update
   ts_pss_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .rx_bit (req_rx_bit),
      .cfg    (cfg),
      .emit   (core_emit),
      .result (core_result)
   );

   // Result register and skid
   ts_pss_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && core_emit),
      .push_data (core_result),
      .can_push  (can_push),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (out_result)
   );

   assign rsp_data_byte     = out_result.data_byte;
   assign rsp_byte_position = out_result.byte_position;

endmodule

`default_nettype wire

>>> dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Testbench for ts_packet_sync_search. Serial bit streams built from packets
// with sync headers, plus noise and broken framing, go in through the
// request channel. A bit-level lock tracker predicts each aligned byte and
// its position in the packet, and every response transfer is checked against
// it. Register settings change between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb;
   import ts_pss_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BITS = 450;
   localparam int MIN_BYTES   = 24;

   // Bit-level model of the lock state machine and queue of predicted bytes
   class sync_tracker;
      logic [7:0]    sync_pat;
      logic [7:0]    inv_pat;
      logic [7:0]    pkt_len;
      logic [3:0]    conf_lim;
      lock_mode_type mode;
      logic [7:0]    window;
      logic [3:0]    conf;
      logic [10:0]   skip;
      logic [7:0]    byte_count;
      result_type    expected_bytes[$];
      int            errors;
      int            checked;
      int            locks;

      function new();
         sync_pat   = SYNC_PATTERN_RST;
         inv_pat    = INV_SYNC_PATTERN_RST;
         pkt_len    = PACKET_BYTES_RST;
         conf_lim   = CONF_LIMIT_RST;
         mode       = MODE_UNLOCKED;
         window     = 8'd0;
         conf       = 4'd0;
         skip       = 11'd1;
         byte_count = 8'd0;
         errors     = 0;
         checked    = 0;
         locks      = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [7:0] val);
         case (idx)
            CSR_SYNC_PATTERN:     sync_pat = val;
            CSR_INV_SYNC_PATTERN: inv_pat  = val;
            CSR_PACKET_BYTES:     pkt_len  = val;
            CSR_CONF_LIMIT:       conf_lim = val[3:0];
            default: ;
         endcase
      endfunction

      // Advance the model by one accepted bit
      function void note_bit(logic b);
         int unsigned eff_len;
         int unsigned lim;
         logic [10:0] spacing;
         bit          emit;
         result_type  r;
         eff_len = (pkt_len == 8'd0) ? 1 : pkt_len;
         lim     = (conf_lim == 4'd0) ? 1 : conf_lim;
         spacing = 11'(eff_len * BITS_PER_BYTE);
         emit    = 1'b0;
         window  = {window[6:0], b};
         if (skip > 11'd1) begin
            skip = skip - 11'd1;
            return;
         end
         case (mode)
            MODE_SEEKING: begin
               if (window == sync_pat) begin
                  conf = 4'(lim);
                  skip = spacing;
               end else if (window == inv_pat) begin
                  conf = 4'(lim);
                  mode = MODE_SYNCED;
                  emit = 1'b1;
                  skip = 11'(BITS_PER_BYTE);
                  locks++;
               end else if (conf <= 4'd1) begin
                  conf = 4'd0;
                  mode = MODE_UNLOCKED;
                  skip = 11'd1;
               end else begin
                  conf = conf - 4'd1;
                  skip = spacing;
               end
            end
            MODE_SYNCED: begin
               emit = 1'b1;
               skip = 11'(BITS_PER_BYTE);
               if (int'(byte_count) + 1 >= eff_len) begin
                  byte_count = 8'd0;
                  if (window == sync_pat || window == inv_pat) begin
                     conf = 4'(lim);
                  end else if (conf <= 4'd1) begin
                     // lost confidence: drop the byte and unlock
                     conf = 4'd0;
                     emit = 1'b0;
                     mode = MODE_UNLOCKED;
                     skip = 11'd1;
                  end else begin
                     conf = conf - 4'd1;
                  end
               end else begin
                  byte_count = byte_count + 8'd1;
               end
            end
            default: begin
               mode = MODE_UNLOCKED;
               if (window == sync_pat) begin
                  if (conf < CONF_MAX) conf = conf + 4'd1;
                  if (conf >= lim) mode = MODE_SEEKING;
                  skip = spacing;
               end else if (conf > 4'd0) begin
                  conf = conf - 4'd1;
                  skip = spacing;
               end else begin
                  skip = 11'd1;
               end
            end
         endcase
         if (emit) begin
            r.data_byte     = window;
            r.byte_position = byte_count;
            expected_bytes.push_back(r);
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      // Compare one response transfer with the oldest prediction
      function void check_byte(logic [7:0] data, logic [7:0] pos);
         result_type exp;
         checked++;
         if (expected_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected byte, expected none, actual data %02h pos %0d",
                     $time, data, pos);
            return;
         end
         exp = expected_bytes.pop_front();
         if (data !== exp.data_byte) begin
            errors++;
            $display("%0t: data_byte mismatch, expected %02h, actual %02h",
                     $time, exp.data_byte, data);
         end
         if (pos !== exp.byte_position) begin
            errors++;
            $display("%0t: byte_position mismatch, expected %0d, actual %0d",
                     $time, exp.byte_position, pos);
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic          req_rx_bit;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [7:0]    rsp_data_byte;
   logic [7:0]    rsp_byte_position;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [7:0]    csr_data;

   sync_tracker   tracker;
   logic [7:0]    cur_sync;
   logic [7:0]    cur_inv;
   logic [7:0]    cur_len;
   logic [3:0]    cur_lim;
   bit            quiet;
   bit            hold_req;
   bit            hold_seen;
   bit            hold_fired;
   int            hold_left;
   int            bits_sent;
   int            settings;
   int            cycles;

   ts_packet_sync_search uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_bit        (req_rx_bit),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_position (rsp_byte_position),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // End the run if it hangs
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Drive rsp_ready: random stalls, quiet stretches, one long hold-off
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = 80;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = quiet || ($urandom_range(99) >= 21);
      end
   end

   // Check each response transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_byte(rsp_data_byte, rsp_byte_position);
   end

   // Offer one bit, idling at random first; hold it until the transfer
   task automatic send_bit(input logic b);
      while (!quiet && $urandom_range(99) < 21) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid  = 1'b1;
      req_rx_bit = b;
      do @(posedge clock); while (!req_ready);
      tracker.note_bit(b);
      bits_sent++;
      // once locked, stall the receiver long enough to back up the input
      if (!hold_fired && tracker.mode == MODE_SYNCED && bits_sent > 60) begin
         hold_fired = 1'b1;
         hold_req   = ~hold_req;
      end
      @(negedge clock);
   endtask

   // Send a byte most significant bit first
   task automatic send_byte(input logic [7:0] v);
      for (int i = 7; i >= 0; i--) send_bit(v[i]);
   endtask

   // Wait until every predicted byte has come out, then let the pipe settle
   task automatic drain();
      req_valid = 1'b0;
      while (tracker.pending() > 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(input logic [7:0] sp, input logic [7:0] ip,
                             input logic [7:0] len, input logic [3:0] lim);
      cur_sync = sp;
      cur_inv  = ip;
      cur_len  = len;
      cur_lim  = lim;
      write_reg(CSR_SYNC_PATTERN, sp);
      write_reg(CSR_INV_SYNC_PATTERN, ip);
      write_reg(CSR_PACKET_BYTES, len);
      write_reg(CSR_CONF_LIMIT, {4'd0, lim});
      settings++;
   endtask

   // Framed stream: sync headers, an inverted header per group, random payload,
   // with the odd corrupted header or slipped bit
   task automatic send_packets();
      int unsigned eff_len;
      int unsigned grp;
      int unsigned npk;
      int unsigned roll;
      logic [7:0]  hdr;
      eff_len = (cur_len == 8'd0) ? 1 : cur_len;
      grp     = ((cur_lim == 4'd0) ? 1 : cur_lim) + 1 + $urandom_range(0, 2);
      npk     = grp * $urandom_range(2, 4);
      repeat ($urandom_range(0, 7)) send_bit(1'($urandom_range(1)));
      for (int k = 0; k < npk; k++) begin
         hdr  = (k % grp == grp - 1) ? cur_inv : cur_sync;
         roll = $urandom_range(99);
         if (roll < 6) hdr = 8'($urandom_range(255));
         else if (roll < 9) send_bit(1'($urandom_range(1)));
         send_byte(hdr);
         for (int j = 1; j < eff_len; j++) send_byte(8'($urandom_range(255)));
      end
   endtask

   initial begin
      int p;
      tracker    = new();
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_rx_bit = 1'b0;
      rsp_ready  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_SYNC_PATTERN;
      csr_data   = 8'd0;
      quiet      = 1'b0;
      hold_req   = 1'b0;
      hold_seen  = 1'b0;
      hold_fired = 1'b0;
      hold_left  = 0;
      bits_sent  = 0;
      settings   = 0;
      cycles     = 0;
      cur_sync   = SYNC_PATTERN_RST;
      cur_inv    = INV_SYNC_PATTERN_RST;
      cur_len    = PACKET_BYTES_RST;
      cur_lim    = CONF_LIMIT_RST;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Zero length and zero limit act as one: lock on one sync byte, sync
      // up on the inverted byte, then lose lock on a bad boundary byte
      write_reg(CSR_PACKET_BYTES, 8'd0);
      write_reg(CSR_CONF_LIMIT, 8'd0);
      cur_len = 8'd0;
      cur_lim = 4'd0;
      send_byte(SYNC_PATTERN_RST);
      send_byte(INV_SYNC_PATTERN_RST);
      send_byte(8'hFF);
      drain();

      // Random phases; state carries over as the settings change
      p = 0;
      while ((bits_sent < RANDOM_BITS || tracker.checked < MIN_BYTES) && p < 40) begin
         quiet = (p == 3);
         case (p)
            0: set_config(8'h00, 8'hFF, 8'd1, 4'd15);
            1: set_config(8'hFF, 8'h00, 8'd255, 4'd15);
            default: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                                ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 3)),
                                ($urandom_range(9) == 0) ? 4'd0 : 4'($urandom_range(1, 3)));
         endcase
         if (p == 1) begin
            // long packets: keep eight ones from lining up so no long skip starts
            for (int i = 0; i < 40; i++) send_bit((i % 4 == 3) ? 1'b0 : 1'($urandom_range(1)));
         end else if (p > 1 && $urandom_range(99) < 12) begin
            repeat ($urandom_range(30, 60)) send_bit(1'($urandom_range(1)));
         end else begin
            send_packets();
         end
         drain();
         p++;
      end

      quiet     = 1'b0;
      req_valid = 1'b0;
      while (tracker.pending() > 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bits over %0d register settings; %0d sync locks", bits_sent,
               settings, tracker.locks);
      $display("Checked %0d aligned bytes, %0d errors", tracker.checked, tracker.errors);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
